>>> sv/eedp_pkg.sv
// shared types and codes for the extended event descriptor parser
`timescale 1ns / 1ps

package eedp_pkg;

  // parser phase
  typedef enum logic [3:0] {
    PH_HDR   = 4'd0,
    PH_LANG  = 4'd1,
    PH_ILEN  = 4'd2,
    PH_DLEN  = 4'd3,
    PH_DCHR  = 4'd4,
    PH_IMLEN = 4'd5,
    PH_ICHR  = 4'd6,
    PH_TLEN  = 4'd7,
    PH_TCHR  = 4'd8,
    PH_DONE  = 4'd9
  } phase_t;

  // field kind tagged on each byte
  typedef enum logic [3:0] {
    KIND_HEADER    = 4'd0,
    KIND_LANG      = 4'd1,
    KIND_ITEMS_LEN = 4'd2,
    KIND_DESC_LEN  = 4'd3,
    KIND_DESC_CHAR = 4'd4,
    KIND_ITEM_LEN  = 4'd5,
    KIND_ITEM_CHAR = 4'd6,
    KIND_TEXT_LEN  = 4'd7,
    KIND_TEXT_CHAR = 4'd8,
    KIND_IGNORED   = 4'd9
  } kind_t;

  // parse status; the error latch uses the same codes (busy means no error)
  typedef enum logic [1:0] {
    ST_BUSY     = 2'd0,
    ST_OK       = 2'd1,
    ST_OVERRUN  = 2'd2,
    ST_MISMATCH = 2'd3
  } status_t;

  localparam int unsigned LangBytes = 3;
  localparam logic [1:0]  LangLast  = 2'(LangBytes - 1);

  // one accepted input word
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       first_byte;
    logic       final_byte;
  } step_in_t;

  // one result word
  typedef struct packed {
    kind_t      field_kind;
    logic [7:0] field_value;
    logic [6:0] item_number;
    logic [3:0] desc_number;
    logic [3:0] last_desc_number;
    status_t    parse_status;
  } result_t;

endpackage

>>> sv/eedp_parser.sv
// parse state registers and the per-byte next-state and tagging logic
`timescale 1ns / 1ps

module eedp_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  eedp_pkg::step_in_t din,
  output eedp_pkg::result_t  res
);
  import eedp_pkg::*;

  phase_t     phase;
  logic [7:0] items_left;
  logic [7:0] field_left;
  logic [6:0] item_cnt;
  logic [1:0] lang_idx;
  logic [7:0] held;
  status_t    err;

  // state seen by this byte, cleared by a first mark
  phase_t     eff_phase;
  logic [7:0] eff_items_left;
  logic [7:0] eff_field_left;
  logic [6:0] eff_item_cnt;
  logic [1:0] eff_lang_idx;
  logic [7:0] eff_held;
  status_t    eff_err;

  // state after this byte, before the end-of-payload clear
  phase_t     step_phase;
  logic [7:0] step_items_left;
  logic [7:0] step_field_left;
  logic [6:0] step_item_cnt;
  logic [1:0] step_lang_idx;
  logic [7:0] step_held;
  status_t    step_err;

  logic [7:0] items_dec;
  logic [7:0] field_dec;
  logic       overrun;

  // restart on first mark
  always_comb begin
    if (din.first_byte) begin
      eff_phase      = PH_HDR;
      eff_items_left = '0;
      eff_field_left = '0;
      eff_item_cnt   = '0;
      eff_lang_idx   = '0;
      eff_held       = '0;
      eff_err        = ST_BUSY;
    end else begin
      eff_phase      = phase;
      eff_items_left = items_left;
      eff_field_left = field_left;
      eff_item_cnt   = item_cnt;
      eff_lang_idx   = lang_idx;
      eff_held       = held;
      eff_err        = err;
    end
  end

  assign items_dec = eff_items_left - 8'd1;
  assign field_dec = eff_field_left - 8'd1;
  assign overrun   = (eff_items_left == 8'd0);

  // next state
  always_comb begin
    step_phase      = eff_phase;
    step_items_left = eff_items_left;
    step_field_left = eff_field_left;
    step_item_cnt   = eff_item_cnt;
    step_lang_idx   = eff_lang_idx;
    step_held       = eff_held;
    step_err        = eff_err;
    if (eff_err == ST_BUSY) begin
      case (eff_phase)
        PH_HDR: begin
          step_held     = din.payload_byte;
          step_lang_idx = '0;
          step_phase    = PH_LANG;
        end
        PH_LANG: begin
          if (eff_lang_idx == LangLast) begin
            step_lang_idx = '0;
            step_phase    = PH_ILEN;
          end else begin
            step_lang_idx = eff_lang_idx + 2'd1;
          end
        end
        PH_ILEN: begin
          step_items_left = din.payload_byte;
          step_phase      = (din.payload_byte != 8'd0) ? PH_DLEN : PH_TLEN;
        end
        PH_DLEN: begin
          if (overrun) begin
            step_err = ST_OVERRUN;
          end else begin
            step_items_left = items_dec;
            step_field_left = din.payload_byte;
            step_phase      = (din.payload_byte != 8'd0) ? PH_DCHR : PH_IMLEN;
          end
        end
        PH_DCHR: begin
          if (overrun) begin
            step_err = ST_OVERRUN;
          end else begin
            step_items_left = items_dec;
            step_field_left = field_dec;
            if (field_dec == 8'd0) step_phase = PH_IMLEN;
          end
        end
        PH_IMLEN: begin
          if (overrun) begin
            step_err = ST_OVERRUN;
          end else begin
            step_items_left = items_dec;
            step_field_left = din.payload_byte;
            if (din.payload_byte != 8'd0) begin
              step_phase = PH_ICHR;
            end else begin
              step_item_cnt = eff_item_cnt + 7'd1;
              step_phase    = (items_dec != 8'd0) ? PH_DLEN : PH_TLEN;
            end
          end
        end
        PH_ICHR: begin
          if (overrun) begin
            step_err = ST_OVERRUN;
          end else begin
            step_items_left = items_dec;
            step_field_left = field_dec;
            if (field_dec == 8'd0) begin
              step_item_cnt = eff_item_cnt + 7'd1;
              step_phase    = (items_dec != 8'd0) ? PH_DLEN : PH_TLEN;
            end
          end
        end
        PH_TLEN: begin
          step_field_left = din.payload_byte;
          step_phase      = (din.payload_byte != 8'd0) ? PH_TCHR : PH_DONE;
        end
        PH_TCHR: begin
          step_field_left = field_dec;
          if (field_dec == 8'd0) step_phase = PH_DONE;
        end
        default: begin
          step_err = ST_MISMATCH;
        end
      endcase
    end
  end

  // result tagging
  always_comb begin
    res.field_value      = din.payload_byte;
    res.item_number      = eff_item_cnt;
    res.desc_number      = step_held[7:4];
    res.last_desc_number = step_held[3:0];
    res.field_kind       = KIND_IGNORED;
    if (eff_err == ST_BUSY) begin
      case (eff_phase)
        PH_HDR:   res.field_kind = KIND_HEADER;
        PH_LANG:  res.field_kind = KIND_LANG;
        PH_ILEN:  res.field_kind = KIND_ITEMS_LEN;
        PH_DLEN:  res.field_kind = overrun ? KIND_IGNORED : KIND_DESC_LEN;
        PH_DCHR:  res.field_kind = overrun ? KIND_IGNORED : KIND_DESC_CHAR;
        PH_IMLEN: res.field_kind = overrun ? KIND_IGNORED : KIND_ITEM_LEN;
        PH_ICHR:  res.field_kind = overrun ? KIND_IGNORED : KIND_ITEM_CHAR;
        PH_TLEN:  res.field_kind = KIND_TEXT_LEN;
        PH_TCHR:  res.field_kind = KIND_TEXT_CHAR;
        default:  res.field_kind = KIND_IGNORED;
      endcase
    end
    if (step_err != ST_BUSY) begin
      res.parse_status = step_err;
    end else if (din.final_byte) begin
      res.parse_status = (step_phase == PH_DONE) ? ST_OK : ST_MISMATCH;
    end else begin
      res.parse_status = ST_BUSY;
    end
  end

  // state registers, cleared after the final byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HDR;
      items_left <= '0;
      field_left <= '0;
      item_cnt   <= '0;
      lang_idx   <= '0;
      held       <= '0;
      err        <= ST_BUSY;
    end else if (step) begin
      if (din.final_byte) begin
        phase      <= PH_HDR;
        items_left <= '0;
        field_left <= '0;
        item_cnt   <= '0;
        lang_idx   <= '0;
        held       <= '0;
        err        <= ST_BUSY;
      end else begin
        phase      <= step_phase;
        items_left <= step_items_left;
        field_left <= step_field_left;
        item_cnt   <= step_item_cnt;
        lang_idx   <= step_lang_idx;
        held       <= step_held;
        err        <= step_err;
      end
    end
  end

`ifndef SYNTHESIS
  // end of payload returns the parser to the header phase
  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    step && din.final_byte |=> phase == PH_HDR && item_cnt == 7'd0 && err == ST_BUSY)
    else $error("parser state not cleared after final byte");

  // a latched error stays until the payload ends or restarts
  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    step && !din.first_byte && !din.final_byte && err != ST_BUSY |=> err == $past(err))
    else $error("error latch changed mid payload");

  // clean completion only on a text length or text byte
  a_ok_on_text: assert property (@(posedge clk) disable iff (rst)
    step && res.parse_status == ST_OK |->
      res.field_kind == KIND_TEXT_LEN || res.field_kind == KIND_TEXT_CHAR)
    else $error("complete status on a non-text byte");
`endif

endmodule

>>> sv/extended_event_descriptor_parser_top.sv
// Extended event descriptor parser: takes the descriptor payload one byte per
// word and returns one tagged word per byte. Each byte passes an input
// register, then the parse step updates the parser state and loads the output
// register in the same cycle, and m_tvalid rises when the output register is
// loaded; the block sustains one byte per cycle under no backpressure.
// s_tuser marks the first payload byte and restarts the parser; s_tlast marks
// the last one, after which the parser is back at the header even without a
// first mark. parse_status shows a latched error (item overrun, or bytes past
// the text) on every later byte of the payload; on the last byte it is
// complete ok if the text ended exactly there and length mismatch otherwise.
`timescale 1ns / 1ps

module extended_event_descriptor_parser_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // payload_byte
  input  logic        s_tuser,   // first_byte
  input  logic        s_tlast,   // final_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // field_value, item_number, desc_number,
                                 // last_desc_number, parse_status, zero pad
  output logic [3:0]  m_tuser    // field_kind
);
  import eedp_pkg::*;

  logic     in_valid;
  step_in_t in_word;
  logic     step;
  result_t  res;
  result_t  out_word;

  // a byte moves on when the output register is free or being drained
  assign step     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || step;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_word.payload_byte <= s_tdata;
      in_word.first_byte   <= s_tuser;
      in_word.final_byte   <= s_tlast;
    end
  end

  eedp_parser u_parser (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .din  (in_word),
    .res  (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_word <= res;
    end
  end

  assign m_tuser = out_word.field_kind;
  assign m_tdata = {7'd0, out_word.parse_status, out_word.last_desc_number,
                    out_word.desc_number, out_word.item_number, out_word.field_value};

`ifndef SYNTHESIS
  // input side stalls only while both registers are full and the sink holds off
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_valid && m_tvalid && !m_tready)
    else $error("input stalled without a full pipeline");
`endif

endmodule

>>> test/extended_event_descriptor_parser_top_test.sv
// self-checking testbench for the extended event descriptor parser top level
`timescale 1ns / 1ps

module extended_event_descriptor_parser_top_test;
  import eedp_pkg::*;

  // one payload byte waiting to be driven
  typedef struct {
    logic [7:0] data;
    logic       first;
    logic       fin;
    bit         drain;
  } payload_word_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // payload_byte
  logic        s_tuser = 1'b0;    // first_byte
  logic        s_tlast = 1'b0;    // final_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;           // field_value, item_number, desc_number,
                                  // last_desc_number, parse_status, zero pad
  logic [3:0]  m_tuser;           // field_kind

  extended_event_descriptor_parser_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // shadow parser state
  phase_t     pr_phase;
  logic [7:0] pr_items_left;
  logic [7:0] pr_field_left;
  logic [6:0] pr_item_cnt;
  logic [1:0] pr_lang_idx;
  logic [7:0] pr_hdr;
  status_t    pr_err;

  result_t       tagged_bytes_q[$];
  payload_word_t pending_q[$];
  logic [7:0]    pl[$];
  result_t       want;
  payload_word_t cur;

  bit hold_next;
  bit src_calm, snk_calm;
  int src_idle, snk_idle;
  int n_err, n_in, n_out, n_ok, n_overrun, n_mismatch;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("timeout with %0d words still expected", tagged_bytes_q.size());
    $display("Verification failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_v);
    $display("mismatch on output word %0d: %s got %0h expected %0h",
             n_out, what, got, exp_v);
    n_err++;
  endtask

  task automatic parser_clear();
    pr_phase      = PH_HDR;
    pr_items_left = 8'd0;
    pr_field_left = 8'd0;
    pr_item_cnt   = 7'd0;
    pr_lang_idx   = 2'd0;
    pr_hdr        = 8'd0;
    pr_err        = ST_BUSY;
  endtask

  task automatic next_item();
    pr_item_cnt = pr_item_cnt + 7'd1;
    pr_phase    = (pr_items_left != 8'd0) ? PH_DLEN : PH_TLEN;
  endtask

  // work out the tagged word for one payload byte
  task automatic parse_byte(input logic [7:0] b, input logic first, input logic fin);
    result_t    r;
    kind_t      kind;
    status_t    st;
    logic [6:0] idx;
    kind = KIND_IGNORED;
    if (first) parser_clear();
    idx = pr_item_cnt;
    if (pr_err == ST_BUSY) begin
      case (pr_phase)
        PH_HDR: begin
          kind        = KIND_HEADER;
          pr_hdr      = b;
          pr_lang_idx = 2'd0;
          pr_phase    = PH_LANG;
        end
        PH_LANG: begin
          kind = KIND_LANG;
          if (pr_lang_idx == LangLast) begin
            pr_lang_idx = 2'd0;
            pr_phase    = PH_ILEN;
          end else begin
            pr_lang_idx = pr_lang_idx + 2'd1;
          end
        end
        PH_ILEN: begin
          kind          = KIND_ITEMS_LEN;
          pr_items_left = b;
          pr_phase      = (b != 8'd0) ? PH_DLEN : PH_TLEN;
        end
        PH_DLEN, PH_DCHR, PH_IMLEN, PH_ICHR: begin
          // every item byte is charged against the items length
          if (pr_items_left == 8'd0) begin
            pr_err = ST_OVERRUN;
          end else begin
            pr_items_left = pr_items_left - 8'd1;
            case (pr_phase)
              PH_DLEN: begin
                kind          = KIND_DESC_LEN;
                pr_field_left = b;
                pr_phase      = (b != 8'd0) ? PH_DCHR : PH_IMLEN;
              end
              PH_DCHR: begin
                kind          = KIND_DESC_CHAR;
                pr_field_left = pr_field_left - 8'd1;
                if (pr_field_left == 8'd0) pr_phase = PH_IMLEN;
              end
              PH_IMLEN: begin
                kind          = KIND_ITEM_LEN;
                pr_field_left = b;
                if (b != 8'd0) pr_phase = PH_ICHR;
                else next_item();
              end
              default: begin
                kind          = KIND_ITEM_CHAR;
                pr_field_left = pr_field_left - 8'd1;
                if (pr_field_left == 8'd0) next_item();
              end
            endcase
          end
        end
        PH_TLEN: begin
          kind          = KIND_TEXT_LEN;
          pr_field_left = b;
          pr_phase      = (b != 8'd0) ? PH_TCHR : PH_DONE;
        end
        PH_TCHR: begin
          kind          = KIND_TEXT_CHAR;
          pr_field_left = pr_field_left - 8'd1;
          if (pr_field_left == 8'd0) pr_phase = PH_DONE;
        end
        default: pr_err = ST_MISMATCH;
      endcase
    end

    if (pr_err != ST_BUSY) st = pr_err;
    else if (fin) st = (pr_phase == PH_DONE) ? ST_OK : ST_MISMATCH;
    else st = ST_BUSY;

    r.field_kind       = kind;
    r.field_value      = b;
    r.item_number      = idx;
    r.desc_number      = pr_hdr[7:4];
    r.last_desc_number = pr_hdr[3:0];
    r.parse_status     = st;
    tagged_bytes_q = {tagged_bytes_q, r};

    if (fin) begin
      if (st == ST_OK) n_ok++;
      else if (st == ST_OVERRUN) n_overrun++;
      else n_mismatch++;
      parser_clear();
    end
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic first, input logic fin);
    payload_word_t w;
    w.data    = b;
    w.first   = first;
    w.fin     = fin;
    w.drain   = hold_next;
    hold_next = 1'b0;
    pending_q = {pending_q, w};
  endtask

  // queue the first n bytes of the payload under construction
  task automatic send_bytes(input int n, input bit first_mark, input bit with_fin);
    for (int i = 0; i < n; i++)
      queue_byte(pl[i], first_mark && i == 0, with_fin && i == n - 1);
  endtask

  // well-formed payload with random content
  task automatic build_payload(input int max_items, input int max_field,
                               input int max_text);
    int n, dl, il, total, tl;
    pl.delete();
    repeat (1 + LangBytes) pl = {pl, 8'($urandom)};
    pl = {pl, 8'd0};
    total = 0;
    n = $urandom_range(0, max_items);
    repeat (n) begin
      dl = $urandom_range(0, max_field);
      il = $urandom_range(0, max_field);
      if (total + 2 + dl + il <= 255) begin
        total += 2 + dl + il;
        pl = {pl, 8'(dl)};
        repeat (dl) pl = {pl, 8'($urandom)};
        pl = {pl, 8'(il)};
        repeat (il) pl = {pl, 8'($urandom)};
      end
    end
    pl[1 + LangBytes] = 8'(total);
    tl = $urandom_range(0, max_text);
    pl = {pl, 8'(tl)};
    repeat (tl) pl = {pl, 8'($urandom)};
  endtask

  // driver: one byte per word, random gaps between words
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      src_idle = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        parse_byte(s_tdata, s_tuser, s_tlast);
        n_in++;
        if ($urandom_range(0, 39) == 0) src_calm = !src_calm;
        src_idle = src_calm ? 0 : $urandom_range(0, 14);
      end
      if (s_tvalid && !s_tready) begin
        // hold the word until taken
      end else if (src_idle != 0) begin
        src_idle--;
        s_tvalid <= 1'b0;
      end else if (pending_q.size() != 0 &&
                   !(pending_q[0].drain && tagged_bytes_q.size() != 0)) begin
        cur = pending_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= cur.data;
        s_tuser  <= cur.first;
        s_tlast  <= cur.fin;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // monitor: compare each output word with the oldest tagged byte
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      snk_idle = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        n_out++;
        if (tagged_bytes_q.size() == 0) begin
          report_mismatch("word with nothing expected", m_tdata, 32'd0);
        end else begin
          want = tagged_bytes_q.pop_front();
          if (m_tuser != want.field_kind)
            report_mismatch("field_kind", 32'(m_tuser), 32'(want.field_kind));
          if (m_tdata[7:0] != want.field_value)
            report_mismatch("field_value", 32'(m_tdata[7:0]), 32'(want.field_value));
          if (m_tdata[14:8] != want.item_number)
            report_mismatch("item_number", 32'(m_tdata[14:8]), 32'(want.item_number));
          if (m_tdata[18:15] != want.desc_number)
            report_mismatch("desc_number", 32'(m_tdata[18:15]), 32'(want.desc_number));
          if (m_tdata[22:19] != want.last_desc_number)
            report_mismatch("last_desc_number", 32'(m_tdata[22:19]),
                            32'(want.last_desc_number));
          if (m_tdata[24:23] != want.parse_status)
            report_mismatch("parse_status", 32'(m_tdata[24:23]),
                            32'(want.parse_status));
          if (m_tdata[31:25] != 7'd0)
            report_mismatch("pad bits", 32'(m_tdata[31:25]), 32'd0);
        end
        if ($urandom_range(0, 39) == 0) snk_calm = !snk_calm;
        snk_idle = snk_calm ? 0 : $urandom_range(0, 14);
      end
      if (snk_idle != 0) begin
        snk_idle--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    int pick, cut;
    parser_clear();

    // header-only payload, first and final on the same byte
    queue_byte(8'hFF, 1'b1, 1'b1);
    // shortest complete payload followed by an extra byte
    pl = {8'h00, 8'hFF, 8'h00, 8'h5A, 8'h00, 8'h00, 8'hFF};
    send_bytes(7, 1'b1, 1'b1);
    // one item with a single description and item char, no first mark
    pl = {8'hA5, 8'h65, 8'h6E, 8'h67, 8'h04, 8'h01, 8'h80, 8'h01, 8'h7F,
          8'h01, 8'hFF};
    send_bytes(11, 1'b0, 1'b1);
    // item length byte beyond the items length
    pl = {8'h12, 8'h01, 8'h02, 8'h03, 8'h01, 8'h00, 8'h00};
    send_bytes(7, 1'b1, 1'b1);

    // random payloads, mostly well formed
    hold_next = 1'b1;
    while (pending_q.size() < 1450) begin
      if ($urandom_range(0, 59) == 0) hold_next = 1'b1;
      if ($urandom_range(0, 29) == 0) build_payload(4, 40, 255);
      else build_payload(3, 6, 12);
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        send_bytes(pl.size(), $urandom_range(0, 7) != 0, 1'b1);
      end else if (pick < 73) begin
        // truncated payload
        cut = $urandom_range(1, pl.size() - 1);
        send_bytes(cut, 1'b1, 1'b1);
      end else if (pick < 80) begin
        // bytes past the end of the text
        repeat ($urandom_range(1, 3)) pl = {pl, 8'($urandom)};
        send_bytes(pl.size(), 1'b1, 1'b1);
      end else if (pick < 88) begin
        // items length off from the real items
        if ($urandom_range(0, 1) == 0 && pl[4] != 8'd0)
          pl[4] = pl[4] - 8'($urandom_range(1, pl[4]));
        else
          pl[4] = pl[4] + 8'($urandom_range(1, 3));
        send_bytes(pl.size(), 1'b1, 1'b1);
      end else if (pick < 93) begin
        // payload cut off by a new first mark
        send_bytes($urandom_range(1, pl.size()), 1'b1, 1'b0);
      end else begin
        // noise with random marks
        repeat ($urandom_range(1, 8))
          queue_byte(8'($urandom), $urandom_range(0, 7) == 0, $urandom_range(0, 5) == 0);
      end
    end
    // close whatever is open
    queue_byte(8'($urandom), 1'b0, 1'b1);

    rst = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (pending_q.size() != 0 || s_tvalid) @(posedge clk);
    while (tagged_bytes_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("%0d bytes in, %0d words out, %0d mismatches", n_in, n_out, n_err);
    $display("payload ends: %0d complete, %0d item overrun, %0d length mismatch",
             n_ok, n_overrun, n_mismatch);
    if (n_err == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

>>> sim.f
sv/eedp_pkg.sv
sv/eedp_parser.sv
sv/extended_event_descriptor_parser_top.sv
test/extended_event_descriptor_parser_top_test.sv
